FILE: sv/ray_box_slab_test_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ray box slab test unit
// Short forms for clocked implication checks used by the checker.
// ----------------------------------------------------------------------------
`ifndef RAY_BOX_SLAB_TEST_UNIT_ASSERT_SVH
`define RAY_BOX_SLAB_TEST_UNIT_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define RBST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbst assertion failed");

// Next-cycle implication, checked during reset as well.
`define RBST_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rbst assertion failed");

`endif

FILE: sv/rbst_pkg.sv
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared constants for the ray box slab test unit.
// ----------------------------------------------------------------------------
package rbst_pkg;

  // Default coordinate format, signed Q16.16.
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // Configuration register index width.
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_LOW_X  = 3'd0,
    REG_BOX_LOW_Y  = 3'd1,
    REG_BOX_LOW_Z  = 3'd2,
    REG_BOX_HIGH_X = 3'd3,
    REG_BOX_HIGH_Y = 3'd4,
    REG_BOX_HIGH_Z = 3'd5
  } cfg_reg_t;

endpackage

FILE: sv/rbst_div_lane.sv
// ----------------------------------------------------------------------------
// rbst_div_lane
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// ----------------------------------------------------------------------------
module rbst_div_lane #(
  parameter int COORD_WIDTH = rbst_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rbst_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [COORD_WIDTH-1:0] mag_i,
  input  logic [COORD_WIDTH-1:0] den_i,
  input  logic                   neg_i,
  output logic [COORD_WIDTH-1:0] quot_o
);

  localparam int W  = COORD_WIDTH;
  localparam int NW = COORD_WIDTH + FRAC_BITS;

  logic [NW-1:0] num_w [0:NW];
  logic [W-1:0]  rem_w [0:NW];
  logic [W-1:0]  qt_w  [0:NW];
  logic [W-1:0]  den_w [0:NW];
  logic          sat_w [0:NW];
  logic          neg_w [0:NW];

  // Stage zero is the numerator scaled by the fraction bits.
  assign num_w[0] = {mag_i, {FRAC_BITS{1'b0}}};
  assign rem_w[0] = '0;
  assign qt_w[0]  = '0;
  assign den_w[0] = den_i;
  assign sat_w[0] = 1'b0;
  assign neg_w[0] = neg_i;

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [NW-1:0] num_r;
    logic [W-1:0]  rem_r;
    logic [W-1:0]  qt_r;
    logic [W-1:0]  den_r;
    logic          sat_r;
    logic          neg_r;
    logic [W-1:0]  rsh;
    logic          ge;

    // One restoring step: shift in a numerator bit, subtract if it fits.
    assign rsh = {rem_w[s][W-2:0], num_w[s][NW-1]};
    assign ge  = (rsh >= den_w[s]);

    always_ff @(posedge clk) begin
      if (en) begin
        num_r <= {num_w[s][NW-2:0], 1'b0};
        rem_r <= ge ? (rsh - den_w[s]) : rsh;
        qt_r  <= {qt_w[s][W-2:0], ge};
        den_r <= den_w[s];
        sat_r <= sat_w[s] | qt_w[s][W-1];
        neg_r <= neg_w[s];
      end
    end

    assign num_w[s+1] = num_r;
    assign rem_w[s+1] = rem_r;
    assign qt_w[s+1]  = qt_r;
    assign den_w[s+1] = den_r;
    assign sat_w[s+1] = sat_r;
    assign neg_w[s+1] = neg_r;
  end

  // Saturate to the signed range, then apply the sign.
  logic [W-1:0] lim;
  logic [W-1:0] qsat;
  logic [W-1:0] quot_r;

  assign lim  = neg_w[NW] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  assign qsat = (sat_w[NW] || (qt_w[NW] > lim)) ? lim : qt_w[NW];

  always_ff @(posedge clk) begin
    if (en) begin
      quot_r <= neg_w[NW] ? (~qsat + 1'b1) : qsat;
    end
  end

  assign quot_o = quot_r;

endmodule

FILE: sv/rbst_slab_merge.sv
// ----------------------------------------------------------------------------
// rbst_slab_merge
// Orders entry and exit distances per axis and narrows the ray interval.
// ----------------------------------------------------------------------------
module rbst_slab_merge #(
  parameter int COORD_WIDTH = rbst_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_WIDTH-1:0] t_lo_i [3],
  input  logic signed [COORD_WIDTH-1:0] t_hi_i [3],
  input  logic        [2:0]             dzero_i,
  input  logic        [2:0]             dneg_i,
  input  logic                          slab_ok_i,
  input  logic signed [COORD_WIDTH-1:0] near_i,
  input  logic signed [COORD_WIDTH-1:0] far_i,
  output logic                          hit_o
);

  localparam int W = COORD_WIDTH;

  logic signed [W-1:0] ent [3];
  logic signed [W-1:0] ext [3];

  // Swap for negative directions; a zero direction leaves the interval alone.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ent[k] = dzero_i[k] ? near_i : (dneg_i[k] ? t_hi_i[k] : t_lo_i[k]);
      ext[k] = dzero_i[k] ? far_i  : (dneg_i[k] ? t_lo_i[k] : t_hi_i[k]);
    end
  end

  // First level of the max and min trees.
  logic signed [W-1:0] mx_a_r, mx_b_r, mn_a_r, mn_b_r;
  logic                ok_b_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mx_a_r <= (ent[0] > near_i) ? ent[0] : near_i;
      mx_b_r <= (ent[1] > ent[2]) ? ent[1] : ent[2];
      mn_a_r <= (ext[0] < far_i)  ? ext[0] : far_i;
      mn_b_r <= (ext[1] < ext[2]) ? ext[1] : ext[2];
      ok_b_r <= slab_ok_i;
    end
  end

  // Second level gives the narrowed interval.
  logic signed [W-1:0] tmin_r, tmax_r;
  logic                ok_c_r;

  always_ff @(posedge clk) begin
    if (en) begin
      tmin_r <= (mx_a_r > mx_b_r) ? mx_a_r : mx_b_r;
      tmax_r <= (mn_a_r < mn_b_r) ? mn_a_r : mn_b_r;
      ok_c_r <= ok_b_r;
    end
  end

  // The ray hits when the interval is not empty and every slab test passed.
  logic hit_r;

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= ok_c_r && !(tmax_r < tmin_r);
    end
  end

  assign hit_o = hit_r;

endmodule

FILE: sv/ray_box_slab_test_unit.sv
// ----------------------------------------------------------------------------
// ray_box_slab_test_unit
// Fixed-point ray versus axis-aligned box slab test, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   The box corners are six configuration registers written through cfg_we,
//   cfg_index and cfg_data; write them only while no request is in flight.
//   Each input request carries a ray origin, a direction and an interval
//   [near_limit, far_limit]; each produces exactly one result, out_hit.
//   Requests pass a prep register, then the six divider lanes that resolve one
//   quotient bit per stage, then the merge registers; default format Q16.16.
//   Throughput is one request per cycle when the receiver does not stall.
//   When out_valid is high and out_stall is high, the whole pipeline holds
//   and in_stall goes high; nothing is lost or repeated.
//   Reset clears all valid bits and sets the box corners to zero.
//   A zero direction component passes its axis only when the origin lies
//   inside that slab. Quotients truncate toward zero and saturate.
// ----------------------------------------------------------------------------
module ray_box_slab_test_unit #(
  parameter int COORD_WIDTH = rbst_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rbst_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration port
  input  logic                           cfg_we,
  input  logic [rbst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]         cfg_data,
  // Input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [COORD_WIDTH-1:0]  in_origin_x,
  input  logic signed [COORD_WIDTH-1:0]  in_origin_y,
  input  logic signed [COORD_WIDTH-1:0]  in_origin_z,
  input  logic signed [COORD_WIDTH-1:0]  in_dir_x,
  input  logic signed [COORD_WIDTH-1:0]  in_dir_y,
  input  logic signed [COORD_WIDTH-1:0]  in_dir_z,
  input  logic signed [COORD_WIDTH-1:0]  in_near_limit,
  input  logic signed [COORD_WIDTH-1:0]  in_far_limit,
  // Result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_hit
);

  localparam int W   = COORD_WIDTH;
  localparam int NW  = COORD_WIDTH + FRAC_BITS;
  localparam int LAT = NW + 5;
  localparam int SBW = 2 * W + 7;

  // Box corner registers.
  logic signed [W-1:0] box_lo_r [3];
  logic signed [W-1:0] box_hi_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        box_lo_r[k] <= '0;
        box_hi_r[k] <= '0;
      end
    end else if (cfg_we) begin
      case (rbst_pkg::cfg_reg_t'(cfg_index))
        rbst_pkg::REG_BOX_LOW_X:  box_lo_r[0] <= cfg_data;
        rbst_pkg::REG_BOX_LOW_Y:  box_lo_r[1] <= cfg_data;
        rbst_pkg::REG_BOX_LOW_Z:  box_lo_r[2] <= cfg_data;
        rbst_pkg::REG_BOX_HIGH_X: box_hi_r[0] <= cfg_data;
        rbst_pkg::REG_BOX_HIGH_Y: box_hi_r[1] <= cfg_data;
        rbst_pkg::REG_BOX_HIGH_Z: box_hi_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline moves unless a finished result is held by the receiver.
  logic en;
  logic [LAT-1:0] vld_r;

  assign en       = !(vld_r[LAT-1] && out_stall);
  assign in_stall = !en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // Prep stage: differences, magnitudes, signs and slab tests.
  logic signed [W-1:0] org [3];
  logic signed [W-1:0] dir [3];
  logic signed [W:0]   d_lo [3];
  logic signed [W:0]   d_hi [3];

  assign org[0] = in_origin_x;
  assign org[1] = in_origin_y;
  assign org[2] = in_origin_z;
  assign dir[0] = in_dir_x;
  assign dir[1] = in_dir_y;
  assign dir[2] = in_dir_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_lo[k] = {box_lo_r[k][W-1], box_lo_r[k]} - {org[k][W-1], org[k]};
      d_hi[k] = {box_hi_r[k][W-1], box_hi_r[k]} - {org[k][W-1], org[k]};
    end
  end

  logic [W-1:0] mag_lo_r [3];
  logic [W-1:0] mag_hi_r [3];
  logic [W-1:0] den_r    [3];
  logic         neg_lo_r [3];
  logic         neg_hi_r [3];
  logic [SBW-1:0] sb_r   [0:NW+1];

  logic [W:0]   abs_lo [3];
  logic [W:0]   abs_hi [3];
  logic [2:0]   dz;
  logic [2:0]   dn;
  logic         slab_ok;

  always_comb begin
    slab_ok = 1'b1;
    for (int k = 0; k < 3; k++) begin
      abs_lo[k] = d_lo[k][W] ? (~d_lo[k] + 1'b1) : d_lo[k];
      abs_hi[k] = d_hi[k][W] ? (~d_hi[k] + 1'b1) : d_hi[k];
      dz[k]     = (dir[k] == '0);
      dn[k]     = dir[k][W-1];
      if (dz[k] && ((org[k] < box_lo_r[k]) || (box_hi_r[k] < org[k]))) begin
        slab_ok = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        mag_lo_r[k] <= abs_lo[k][W-1:0];
        mag_hi_r[k] <= abs_hi[k][W-1:0];
        den_r[k]    <= dn[k] ? (~dir[k] + 1'b1) : dir[k];
        neg_lo_r[k] <= d_lo[k][W] ^ dn[k];
        neg_hi_r[k] <= d_hi[k][W] ^ dn[k];
      end
      sb_r[0] <= {in_near_limit, in_far_limit, dz, dn, slab_ok};
    end
  end

  // Side information travels alongside the divider lanes.
  for (genvar s = 1; s <= NW + 1; s++) begin : g_sb
    always_ff @(posedge clk) begin
      if (en) begin
        sb_r[s] <= sb_r[s-1];
      end
    end
  end

  // Six divider lanes: low and high corner for each axis.
  logic [W-1:0] t_lo [3];
  logic [W-1:0] t_hi [3];

  for (genvar k = 0; k < 3; k++) begin : g_axis
    rbst_div_lane #(
      .COORD_WIDTH(COORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_div_lo (
      .clk   (clk),
      .en    (en),
      .mag_i (mag_lo_r[k]),
      .den_i (den_r[k]),
      .neg_i (neg_lo_r[k]),
      .quot_o(t_lo[k])
    );

    rbst_div_lane #(
      .COORD_WIDTH(COORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_div_hi (
      .clk   (clk),
      .en    (en),
      .mag_i (mag_hi_r[k]),
      .den_i (den_r[k]),
      .neg_i (neg_hi_r[k]),
      .quot_o(t_hi[k])
    );
  end

  // Interval narrowing and final hit decision.
  logic signed [W-1:0] t_lo_s [3];
  logic signed [W-1:0] t_hi_s [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t_lo_s[k] = t_lo[k];
      t_hi_s[k] = t_hi[k];
    end
  end

  rbst_slab_merge #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_merge (
    .clk      (clk),
    .en       (en),
    .t_lo_i   (t_lo_s),
    .t_hi_i   (t_hi_s),
    .dzero_i  (sb_r[NW+1][6:4]),
    .dneg_i   (sb_r[NW+1][3:1]),
    .slab_ok_i(sb_r[NW+1][0]),
    .near_i   (sb_r[NW+1][SBW-1:W+7]),
    .far_i    (sb_r[NW+1][W+6:7]),
    .hit_o    (out_hit)
  );

endmodule

FILE: sv/rbst_checker.sv
// ----------------------------------------------------------------------------
// rbst_checker
// Port-level checks of the ray box slab test unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "ray_box_slab_test_unit_assert.svh"

module rbst_checker (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_hit
);

  // The input side stalls exactly when a result is held by the receiver.
  `RBST_ASSERT_IMP(a_stall_link, 1'b1, in_stall == (out_valid && out_stall))

  // With no valid result at the output, the input is never stalled.
  `RBST_ASSERT_IMP(a_no_idle_stall, !out_valid, !in_stall)

  // A held result stays valid and unchanged.
  `RBST_ASSERT_NXT(a_hold, rst_n && out_valid && out_stall, out_valid && $stable(out_hit))

  // Reset empties the pipeline.
  `RBST_ASSERT_NXT(a_reset_empty, !rst_n, !out_valid)

endmodule

bind ray_box_slab_test_unit rbst_checker u_rbst_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_hit  (out_hit)
);

FILE: sim/ray_box_slab_test_unit_tb.sv
// ----------------------------------------------------------------------------
// ray_box_slab_test_unit_tb
// Self-checking bench for the fixed-point ray versus box slab test.
// Rays are driven through a queue-fed driver with random gaps. Each accepted
// request is scored by a slab-test predictor kept in the bench. A monitor
// compares every hit flag with the oldest prediction. The box corners change
// between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module ray_box_slab_test_unit_tb;

  localparam int W       = 32;
  localparam int FB      = 16;
  localparam int LATENCY = W + FB + 5;
  localparam int LIMIT   = 2000000;

  typedef logic signed [W-1:0] coord_t;
  typedef struct packed {
    coord_t org_x, org_y, org_z, dir_x, dir_y, dir_z, near_t, far_t;
  } ray_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [rbst_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  ray_t cur = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;

  coord_t box_lo [3];
  coord_t box_hi [3];
  ray_t pending_rays [$];
  logic hit_expected [$];
  int errors = 0;
  int hits_seen = 0;
  int results_seen = 0;
  int cycle = 0;
  int idle_pct = 30;
  bit hold_off = 1'b0;
  int hold_left = 0;

  always #2 clk = ~clk;

  ray_box_slab_test_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_origin_x(cur.org_x), .in_origin_y(cur.org_y), .in_origin_z(cur.org_z),
    .in_dir_x(cur.dir_x), .in_dir_y(cur.dir_y), .in_dir_z(cur.dir_z),
    .in_near_limit(cur.near_t), .in_far_limit(cur.far_t),
    .out_valid(out_valid), .out_stall(out_stall), .out_hit(out_hit)
  );

  // Distance (a - b) / d in fixed point, truncated toward zero and saturated.
  function automatic coord_t slab_distance(coord_t a, coord_t b, coord_t d);
    logic signed [W:0] diff;
    logic [W+FB:0] num;
    logic [W:0] den;
    logic [W+FB:0] quo;
    logic neg;
    diff = $signed({a[W-1], a}) - $signed({b[W-1], b});
    neg = diff[W] ^ d[W-1];
    num = diff[W] ? (W+FB+1)'(-diff) << FB : (W+FB+1)'(diff) << FB;
    den = d[W-1] ? -{d[W-1], d} : {1'b0, d};
    quo = num / den;
    if (num == 0) return '0;
    if (neg) begin
      if (quo > (W+FB+1)'(64'h8000_0000)) return {1'b1, {(W-1){1'b0}}};
      return coord_t'(-quo);
    end
    if (quo > (W+FB+1)'(64'h7FFF_FFFF)) return {1'b0, {(W-1){1'b1}}};
    return coord_t'(quo);
  endfunction

  // Slab test over the three axes, narrowing the interval.
  function automatic logic ray_hits_box(ray_t r);
    coord_t org [3];
    coord_t dir [3];
    coord_t t_near, t_far, t0, t1, tmp;
    logic hit;
    org = '{r.org_x, r.org_y, r.org_z};
    dir = '{r.dir_x, r.dir_y, r.dir_z};
    t_near = r.near_t;
    t_far = r.far_t;
    hit = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (!hit) break;
      if (dir[k] == 0) begin
        if (org[k] < box_lo[k] || box_hi[k] < org[k]) hit = 1'b0;
      end else begin
        t0 = slab_distance(box_lo[k], org[k], dir[k]);
        t1 = slab_distance(box_hi[k], org[k], dir[k]);
        if (dir[k] < 0) begin
          tmp = t0; t0 = t1; t1 = tmp;
        end
        if (t_near < t0) t_near = t0;
        if (t1 < t_far) t_far = t1;
      end
      if (hit && t_far < t_near) hit = 1'b0;
    end
    return hit;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle, what);
    errors++;
  endtask

  // Driver: presents queued requests with random idle cycles.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (in_valid && !in_stall) hit_expected.push_back(ray_hits_box(cur));
    if (!in_valid || !in_stall) begin
      if (pending_rays.size() > 0 && $urandom_range(99) >= idle_pct) begin
        cur <= pending_rays.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted down in cycles.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_off) begin
      hold_left <= 300;
    end
  end

  // Monitor: stalls at random and checks each accepted hit flag.
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      results_seen++;
      if (out_hit) hits_seen++;
      if (hit_expected.size() == 0) report_mismatch("result with nothing pending");
      else if (out_hit !== hit_expected.pop_front())
        report_mismatch($sformatf("hit flag %b is wrong", out_hit));
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  always @(posedge clk) begin
    if (cycle > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_reg(input rbst_pkg::cfg_reg_t idx, input coord_t val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    box_lo[idx % 3] = (idx < rbst_pkg::REG_BOX_HIGH_X) ? val : box_lo[idx % 3];
    box_hi[idx % 3] = (idx >= rbst_pkg::REG_BOX_HIGH_X) ? val : box_hi[idx % 3];
  endtask

  task automatic set_box(input coord_t lx, ly, lz, hx, hy, hz);
    write_reg(rbst_pkg::REG_BOX_LOW_X, lx);
    write_reg(rbst_pkg::REG_BOX_LOW_Y, ly);
    write_reg(rbst_pkg::REG_BOX_LOW_Z, lz);
    write_reg(rbst_pkg::REG_BOX_HIGH_X, hx);
    write_reg(rbst_pkg::REG_BOX_HIGH_Y, hy);
    write_reg(rbst_pkg::REG_BOX_HIGH_Z, hz);
    cfg_we <= 1'b0;
  endtask

  // Wait until the pipeline has drained, then let it settle.
  task automatic drain;
    while (pending_rays.size() > 0 || in_valid || hit_expected.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic coord_t rand_coord(input int span);
    case ($urandom_range(9))
      0: return coord_t'($urandom);
      1: return {1'b0, {(W-1){1'b1}}};
      2: return {1'b1, {(W-1){1'b0}}};
      3: return '0;
      default: return coord_t'($signed($urandom_range(2 * span)) - span);
    endcase
  endfunction

  function automatic coord_t rand_dir();
    case ($urandom_range(7))
      0: return '0;
      1: return coord_t'($urandom);
      2: return coord_t'($signed($urandom_range(64)) - 32);
      default: return coord_t'($signed($urandom_range(32'h40000)) - 32'h20000);
    endcase
  endfunction

  // Mostly rays aimed from outside toward the box, the rest fully random.
  task automatic queue_random(input int count);
    ray_t r;
    coord_t tx, ty, tz;
    for (int i = 0; i < count; i++) begin
      r.dir_x = rand_dir(); r.dir_y = rand_dir(); r.dir_z = rand_dir();
      if ($urandom_range(3) != 0) begin
        tx = box_lo[0] + coord_t'($urandom_range(32'h30000));
        ty = box_lo[1] + coord_t'($urandom_range(32'h30000));
        tz = box_lo[2] + coord_t'($urandom_range(32'h30000));
        r.org_x = tx - (r.dir_x >>> 14) * 4;
        r.org_y = ty - (r.dir_y >>> 14) * 4;
        r.org_z = tz - (r.dir_z >>> 14) * 4;
        r.near_t = coord_t'($signed($urandom_range(32'h40000)) - 32'h20000);
        r.far_t = r.near_t + coord_t'($urandom_range(32'h100000));
      end else begin
        r.org_x = rand_coord(32'h80000); r.org_y = rand_coord(32'h80000);
        r.org_z = rand_coord(32'h80000);
        r.near_t = rand_coord(32'h100000); r.far_t = rand_coord(32'h100000);
      end
      pending_rays.push_back(r);
    end
  endtask

  initial begin
    ray_t r;
    coord_t mx, mn;
    mx = {1'b0, {(W-1){1'b1}}};
    mn = {1'b1, {(W-1){1'b0}}};
    for (int k = 0; k < 3; k++) begin
      box_lo[k] = '0;
      box_hi[k] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: unit box, axis rays, zero directions, empty and extreme ranges.
    set_box(32'h0, 32'h0, 32'h0, 32'h10000, 32'h10000, 32'h10000);
    r = '{-32'h10000, 32'h8000, 32'h8000, 32'h10000, 0, 0, 0, 32'h100000};
    pending_rays.push_back(r);
    r.dir_x = -32'h10000; r.org_x = 32'h20000;
    pending_rays.push_back(r);
    r.org_y = 32'h20000;
    pending_rays.push_back(r);
    r = '{32'h8000, 32'h8000, 32'h8000, 0, 0, 0, 0, 32'h10000};
    pending_rays.push_back(r);
    r.near_t = 32'h20000;
    pending_rays.push_back(r);
    r = '{mn, mn, mn, 1, 1, 1, mn, mx};
    pending_rays.push_back(r);
    r = '{mx, mx, mx, mn, mn, mn, mn, mx};
    pending_rays.push_back(r);
    r = '{mx, mn, 0, mx, mx, -1, mn, mx};
    pending_rays.push_back(r);
    r = '{-32'h10000, -32'h10000, -32'h10000, 1, 32'h10000, mx, 0, mx};
    pending_rays.push_back(r);
    r = '{32'h8000, 32'h8000, 32'h8000, 32'h10000, 32'h10000, 32'h10000, mx, mn};
    pending_rays.push_back(r);
    r = '{0, 32'h10000, 0, 32'h10000, 0, 0, 0, 0};
    pending_rays.push_back(r);
    drain();

    // Extreme box corners, then an inverted box.
    set_box(mn, mn, mn, mx, mx, mx);
    queue_random(40);
    drain();
    set_box(32'h10000, 32'h10000, 32'h10000, 0, 0, 0);
    queue_random(40);
    drain();

    // Receiver holds off while the sender keeps offering rays.
    set_box(-32'h8000, -32'h20000, 32'h0, 32'h8000, 32'h10000, 32'h30000);
    queue_random(200);
    idle_pct = 0;
    hold_off = 1'b1;
    wait (hold_left > 0);
    hold_off = 1'b0;
    drain();
    idle_pct = 30;

    // Random boxes, including a stretch with no idling.
    for (int p = 0; p < 6; p++) begin
      mn = coord_t'($signed($urandom_range(32'h80000)) - 32'h40000);
      set_box(mn, mn - 32'h1000, mn + 32'h800,
              mn + coord_t'($urandom_range(32'h40000)),
              mn + coord_t'($urandom_range(32'h40000)),
              mn + coord_t'($urandom_range(32'h40000)));
      if (p == 3) idle_pct = 0;
      queue_random(170);
      drain();
      idle_pct = 30;
    end

    $display("Checked %0d ray requests, %0d hits, over ten box settings.",
             results_seen, hits_seen);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
